### src/dmwc_pkg.sv
// shared types and constants for the direct-mapped write-back cache
// no dependencies; used by the top level and the port checker
`timescale 1ns / 1ps

package dmwc_pkg;

    localparam int TAG_BITS_DEF      = 4;
    localparam int INDEX_BITS_DEF    = 6;
    localparam int WORD_SEL_BITS_DEF = 2;
    localparam int BYTE_BITS_DEF     = 2;

    localparam int ADDR_W  = 14;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = 32;
    localparam int KIND_W  = 2;

    // access kind on the request side
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // outcome codes on the result side
    localparam logic [KIND_W-1:0] OUT_READ_HIT  = 2'd0;
    localparam logic [KIND_W-1:0] OUT_READ_MISS = 2'd1;
    localparam logic [KIND_W-1:0] OUT_WRITE     = 2'd2;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_LOOKUP = 7'b0000100,
        ST_WBACK  = 7'b0001000,
        ST_FILL   = 7'b0010000,
        ST_ACCESS = 7'b0100000,
        ST_RESP   = 7'b1000000
    } state_t;

endpackage

### src/dmwc_ram.sv
// single-port synchronous ram with registered read data
// no dependencies; used for tag, line and backing stores
`timescale 1ns / 1ps

module dmwc_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/direct_mapped_writeback_cache_top.sv
// sequence: a request taken in IDLE passes LOOKUP, ACCESS and RESP on a hit; a miss
// adds a line fill (FILL) before ACCESS, a dirty victim a write-back (WBACK) before it
// one request at a time: no new request is taken until the previous result is registered;
// a result still waiting on m_axis_tready holds the next one back
// reset: asynchronous, then a pass over all 2**(TAG_BITS+INDEX_BITS+WORD_SEL_BITS)
// backing addresses zeroes backing memory and tags; no request is taken until it ends
`timescale 1ns / 1ps

// sequencer, tag/line/backing stores and counters of the cache
// depends on dmwc_pkg and dmwc_ram
module direct_mapped_writeback_cache_top #(
    parameter int TAG_BITS      = dmwc_pkg::TAG_BITS_DEF,
    parameter int INDEX_BITS    = dmwc_pkg::INDEX_BITS_DEF,
    parameter int WORD_SEL_BITS = dmwc_pkg::WORD_SEL_BITS_DEF,
    parameter int BYTE_BITS     = dmwc_pkg::BYTE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // address[13:0], write_data[45:14], zero pad
    input  logic [0:0]   s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // read_data, total_reads, total_writes,
                                         // total_hits, total_misses
    output logic [1:0]   m_axis_tuser    // outcome
);

    localparam int LINE_WORDS = 2 ** WORD_SEL_BITS;
    localparam int LCNT_W     = WORD_SEL_BITS + 1;
    localparam int FIELD_W    = BYTE_BITS + WORD_SEL_BITS + INDEX_BITS + TAG_BITS;
    localparam int EXT_W      = (FIELD_W > dmwc_pkg::ADDR_W) ? FIELD_W : dmwc_pkg::ADDR_W;
    localparam int LINE_AW    = INDEX_BITS + WORD_SEL_BITS;
    localparam int MEM_AW     = TAG_BITS + INDEX_BITS + WORD_SEL_BITS;
    localparam int TENT_W     = TAG_BITS + 2;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
    } tag_entry_t;

    dmwc_pkg::state_t state_reg, state_next;

    logic [MEM_AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [LCNT_W-1:0]        wcnt_reg, wcnt_next;
    logic [LCNT_W-1:0]        wcnt_prev;

    logic                     req_func_reg, req_func_next;
    logic [TAG_BITS-1:0]      req_tag_reg, req_tag_next;
    logic [INDEX_BITS-1:0]    req_idx_reg, req_idx_next;
    logic [WORD_SEL_BITS-1:0] req_word_reg, req_word_next;
    logic [dmwc_pkg::WORD_W-1:0] req_wdata_reg, req_wdata_next;
    logic [TAG_BITS-1:0]      vict_tag_reg, vict_tag_next;
    logic                     hit_reg, hit_next;

    logic                     out_valid_reg, out_valid_next;
    logic [dmwc_pkg::KIND_W-1:0] outcome_reg, outcome_next;
    logic [dmwc_pkg::WORD_W-1:0] rdata_out_reg, rdata_out_next;
    logic [dmwc_pkg::CNT_W-1:0] reads_reg, reads_next;
    logic [dmwc_pkg::CNT_W-1:0] writes_reg, writes_next;
    logic [dmwc_pkg::CNT_W-1:0] hits_reg, hits_next;
    logic [dmwc_pkg::CNT_W-1:0] misses_reg, misses_next;

    logic [EXT_W-1:0]         addr_ext;
    logic                     accept;
    logic                     out_free;
    logic                     hit;

    logic                     tag_en, tag_we;
    logic [INDEX_BITS-1:0]    tag_addr;
    tag_entry_t               tag_wdata, tag_rdata;
    logic [TENT_W-1:0]        tag_rdata_raw;

    logic                     line_en, line_we;
    logic [LINE_AW-1:0]       line_addr;
    logic [dmwc_pkg::WORD_W-1:0] line_wdata, line_rdata;

    logic                     mem_en, mem_we;
    logic [MEM_AW-1:0]        mem_addr;
    logic [dmwc_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

    dmwc_ram #(.DATA_W(TENT_W), .ADDR_W(INDEX_BITS)) u_tag_ram (
        .clk   (clk),
        .en    (tag_en),
        .we    (tag_we),
        .addr  (tag_addr),
        .wdata (tag_wdata),
        .rdata (tag_rdata_raw)
    );

    dmwc_ram #(.DATA_W(dmwc_pkg::WORD_W), .ADDR_W(LINE_AW)) u_line_ram (
        .clk   (clk),
        .en    (line_en),
        .we    (line_we),
        .addr  (line_addr),
        .wdata (line_wdata),
        .rdata (line_rdata)
    );

    dmwc_ram #(.DATA_W(dmwc_pkg::WORD_W), .ADDR_W(MEM_AW)) u_mem_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign tag_rdata = tag_entry_t'(tag_rdata_raw);

    assign addr_ext  = EXT_W'(s_axis_tdata[dmwc_pkg::ADDR_W-1:0]);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign hit       = tag_rdata.valid && (tag_rdata.tag == req_tag_reg);
    assign wcnt_prev = wcnt_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        wcnt_next      = wcnt_reg;
        req_func_next  = req_func_reg;
        req_tag_next   = req_tag_reg;
        req_idx_next   = req_idx_reg;
        req_word_next  = req_word_reg;
        req_wdata_next = req_wdata_reg;
        vict_tag_next  = vict_tag_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        outcome_next   = outcome_reg;
        rdata_out_next = rdata_out_reg;
        reads_next     = reads_reg;
        writes_next    = writes_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;

        tag_en     = 1'b0;
        tag_we     = 1'b0;
        tag_addr   = req_idx_reg;
        tag_wdata  = '0;
        line_en    = 1'b0;
        line_we    = 1'b0;
        line_addr  = {req_idx_reg, req_word_reg};
        line_wdata = req_wdata_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = {req_tag_reg, req_idx_reg, wcnt_reg[WORD_SEL_BITS-1:0]};
        mem_wdata  = line_rdata;

        case (state_reg)
            dmwc_pkg::ST_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
                tag_en    = 1'b1;
                tag_we    = 1'b1;
                tag_addr  = clr_cnt_reg[INDEX_BITS-1:0];
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = dmwc_pkg::ST_IDLE;
                end
            end
            dmwc_pkg::ST_IDLE:
            begin
                tag_addr = addr_ext[BYTE_BITS+LINE_AW-1 -: INDEX_BITS];
                if (accept)
                begin
                    tag_en         = 1'b1;
                    req_func_next  = s_axis_tuser[0];
                    req_word_next  = addr_ext[BYTE_BITS +: WORD_SEL_BITS];
                    req_idx_next   = addr_ext[BYTE_BITS+WORD_SEL_BITS +: INDEX_BITS];
                    req_tag_next   = addr_ext[FIELD_W-1 -: TAG_BITS];
                    req_wdata_next = s_axis_tdata[dmwc_pkg::ADDR_W +: dmwc_pkg::WORD_W];
                    state_next     = dmwc_pkg::ST_LOOKUP;
                end
            end
            dmwc_pkg::ST_LOOKUP:
            begin
                hit_next      = hit;
                vict_tag_next = tag_rdata.tag;
                wcnt_next     = '0;
                if (hit)
                begin
                    state_next = dmwc_pkg::ST_ACCESS;
                end
                else if (tag_rdata.valid && tag_rdata.dirty)
                begin
                    state_next = dmwc_pkg::ST_WBACK;
                end
                else
                begin
                    state_next = dmwc_pkg::ST_FILL;
                end
            end
            dmwc_pkg::ST_WBACK:
            begin
                // read line word n while word n-1 goes to backing memory
                line_addr = {req_idx_reg, wcnt_reg[WORD_SEL_BITS-1:0]};
                line_en   = (wcnt_reg != LCNT_W'(LINE_WORDS));
                mem_addr  = {vict_tag_reg, req_idx_reg, wcnt_prev[WORD_SEL_BITS-1:0]};
                mem_wdata = line_rdata;
                mem_en    = (wcnt_reg != '0);
                mem_we    = (wcnt_reg != '0);
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == LCNT_W'(LINE_WORDS))
                begin
                    wcnt_next  = '0;
                    state_next = dmwc_pkg::ST_FILL;
                end
            end
            dmwc_pkg::ST_FILL:
            begin
                mem_addr   = {req_tag_reg, req_idx_reg, wcnt_reg[WORD_SEL_BITS-1:0]};
                mem_en     = (wcnt_reg != LCNT_W'(LINE_WORDS));
                line_addr  = {req_idx_reg, wcnt_prev[WORD_SEL_BITS-1:0]};
                line_wdata = mem_rdata;
                line_en    = (wcnt_reg != '0);
                line_we    = (wcnt_reg != '0);
                wcnt_next  = wcnt_reg + 1'b1;
                if (wcnt_reg == LCNT_W'(LINE_WORDS))
                begin
                    tag_en     = 1'b1;
                    tag_we     = 1'b1;
                    tag_wdata  = '{valid: 1'b1, dirty: 1'b0, tag: req_tag_reg};
                    state_next = dmwc_pkg::ST_ACCESS;
                end
            end
            dmwc_pkg::ST_ACCESS:
            begin
                line_en = 1'b1;
                if (req_func_reg == dmwc_pkg::FUNC_WRITE)
                begin
                    line_we   = 1'b1;
                    tag_en    = 1'b1;
                    tag_we    = 1'b1;
                    tag_wdata = '{valid: 1'b1, dirty: 1'b1, tag: req_tag_reg};
                end
                state_next = dmwc_pkg::ST_RESP;
            end
            dmwc_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (req_func_reg == dmwc_pkg::FUNC_WRITE)
                    begin
                        outcome_next   = dmwc_pkg::OUT_WRITE;
                        rdata_out_next = '0;
                        writes_next    = writes_reg + 1'b1;
                    end
                    else
                    begin
                        rdata_out_next = line_rdata;
                        reads_next     = reads_reg + 1'b1;
                        if (hit_reg)
                        begin
                            outcome_next = dmwc_pkg::OUT_READ_HIT;
                            hits_next    = hits_reg + 1'b1;
                        end
                        else
                        begin
                            outcome_next = dmwc_pkg::OUT_READ_MISS;
                            misses_next  = misses_reg + 1'b1;
                        end
                    end
                    state_next = dmwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmwc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmwc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            wcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            reads_reg     <= '0;
            writes_reg    <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            wcnt_reg      <= wcnt_next;
            out_valid_reg <= out_valid_next;
            reads_reg     <= reads_next;
            writes_reg    <= writes_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_func_reg  <= req_func_next;
        req_tag_reg   <= req_tag_next;
        req_idx_reg   <= req_idx_next;
        req_word_reg  <= req_word_next;
        req_wdata_reg <= req_wdata_next;
        vict_tag_reg  <= vict_tag_next;
        hit_reg       <= hit_next;
        outcome_reg   <= outcome_next;
        rdata_out_reg <= rdata_out_next;
    end

    assign s_axis_tready = (state_reg == dmwc_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = outcome_reg;
    assign m_axis_tdata  = {misses_reg, hits_reg, writes_reg, reads_reg, rdata_out_reg};

endmodule

### src/dmwc_checker.sv
// port-level checks of the cache request and result streams, bound to the top level
// depends on dmwc_pkg and direct_mapped_writeback_cache_top
`timescale 1ns / 1ps

module dmwc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request at a time: busy right after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // writes return zero data and have been counted
    a_write_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == dmwc_pkg::OUT_WRITE
            |-> m_axis_tdata[31:0] == '0 && m_axis_tdata[95:64] != '0)
        else $error("write result malformed");

    // a read result has been counted as a read and as a hit or miss
    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == dmwc_pkg::OUT_READ_HIT
                          || m_axis_tuser == dmwc_pkg::OUT_READ_MISS)
            |-> m_axis_tdata[63:32] != '0
                && (m_axis_tdata[127:96] != '0 || m_axis_tdata[159:128] != '0))
        else $error("read result not counted");

    // results only carry a defined outcome code
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser == dmwc_pkg::OUT_READ_HIT
                          || m_axis_tuser == dmwc_pkg::OUT_READ_MISS
                          || m_axis_tuser == dmwc_pkg::OUT_WRITE)
        else $error("bad outcome code");

endmodule

bind direct_mapped_writeback_cache_top dmwc_checker u_dmwc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
